>>> design/nxd_pkg.sv
// ----------------------------------------------------------------------------
// nxd_pkg
// Shared types and constants of the nibble-XOR delta sector decoder.
// ----------------------------------------------------------------------------
package nxd_pkg;

  // sector geometry
  localparam int SECTOR_BYTES_DEF     = 512;
  localparam int PAYLOAD_START_NIBBLE = 40;
  localparam int HEADER_END           = PAYLOAD_START_NIBBLE / 2 - 1;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 11;
  localparam int COUNT_MAX = 1024;
  localparam int OUT_DATA_W = 40;

  // parse phases
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CTRL_HI = 2'd1,
    PH_CTRL_LO = 2'd2,
    PH_DATA    = 2'd3
  } phase_t;

  // one decoded result beat
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [COUNT_W-1:0]  count;
    logic                sample_valid;
    logic                done;
    logic                term;
  } res_t;

endpackage

>>> design/nibble_xor_delta_sector_decoder_core.sv
// ----------------------------------------------------------------------------
// nibble_xor_delta_sector_decoder_core
// Decodes logger sectors of nibble-XOR delta records into channel samples.
// ----------------------------------------------------------------------------
// Feed the sector one byte per beat, with in_tuser high on byte 0. The start
// value of the selected channel comes out on byte 19, then one beat per
// completed record of that channel; the beat that ends the parse has tlast
// set and tuser[1] tells a zero channel code from a sector that ran out.
// One byte is taken every cycle while the result side is not back-pressured; a
// result passes from the input register to the result register. The rate is set by
// the two-nibble decode that sits in one pass between those registers. There is no
// clearing pass after reset. Write channel_select only while the block is idle.
// ----------------------------------------------------------------------------
module nibble_xor_delta_sector_decoder_core
  import nxd_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data,   // channel_select
  // sector bytes
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // sector_byte
  input  logic                  in_tuser,   // first_byte
  // samples
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample_value[23:0], sample_count[34:24], zeros
  output logic                  out_tlast,  // sector_done
  output logic [1:0]            out_tuser   // sample_valid, terminated
);

  logic [1:0] sel_r;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_first;
  logic       can_load;
  logic       fire;
  logic       res_valid;
  res_t       res;

  // channel select register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      sel_r <= cfg_data;
    end
  end

  // input register
  nxd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (can_load),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_first (hold_first)
  );

  assign fire = hold_valid && can_load;

  // decode
  nxd_parser #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel       (sel_r),
    .fire      (fire),
    .in_byte   (hold_byte),
    .in_first  (hold_first),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  nxd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // every beat carries a sample or the end of the parse
  a_beat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || out_tlast))
    else $error("result beat with neither sample nor end");

  // no sample means a zero value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[23:0] == 24'd0))
    else $error("value set without a sample");

  // terminated only on the ending beat
  a_term_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("terminated without sector end");

  // a held byte blocks new bytes only while the result side stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");
`endif

endmodule

>>> design/nxd_in_stage.sv
// ----------------------------------------------------------------------------
// nxd_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module nxd_in_stage
  import nxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // sector_byte
  input  logic       in_tuser,   // first_byte
  input  logic       advance,    // parser consumes the held beat this cycle
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  output logic       hold_first
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       take;

  // free when empty or when the held beat leaves this cycle
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
  assign hold_first = first_r;

endmodule

>>> design/nxd_parser.sv
// ----------------------------------------------------------------------------
// nxd_parser
// Sector parse state and the single-pass decode of one byte (two nibbles).
// ----------------------------------------------------------------------------
module nxd_parser
  import nxd_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] sel,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  output logic       res_valid,
  output res_t       res
);

  localparam int POS_W = $clog2(SECTOR_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);

  typedef struct packed {
    phase_t              phase;
    logic [3:0]          pend;
    logic [5:0]          mask;
    logic [1:0]          chan;
    logic [SAMPLE_W-1:0] delta;
    logic [SAMPLE_W-1:0] run;
    logic                emit;
    logic                term;
    logic                fin;
  } nib_state_t;

  // state registers
  phase_t              phase_r;
  logic [3:0]          pend_r;
  logic [5:0]          mask_r;
  logic [1:0]          chan_r;
  logic [SAMPLE_W-1:0] delta_r;
  logic [SAMPLE_W-1:0] run_r;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                fin_r;

  nib_state_t          cur, s0, s1, s2;
  logic [COUNT_W-1:0]  cur_cnt;
  logic [POS_W-1:0]    cur_pos;
  logic [POS_W-1:0]    hdr_base;
  logic [POS_W-1:0]    hdr_off;
  logic                done;

  // close a record: fold the delta in when its channel is selected
  function automatic nib_state_t finish_rec(nib_state_t s, logic [1:0] sl);
    nib_state_t r;
    r = s;
    if (s.chan == sl) begin
      r.run  = s.run ^ s.delta;
      r.emit = 1'b1;
    end
    r.phase = PH_CTRL_HI;
    return r;
  endfunction

  // consume one payload nibble
  function automatic nib_state_t nibble_step(nib_state_t s, logic [3:0] n, logic [1:0] sl);
    nib_state_t r;
    logic [5:0] m;
    logic [2:0] b;
    r = s;
    m = '0;
    b = '0;
    case (s.phase)
      PH_CTRL_HI: begin
        if (n[3:2] == 2'b00) begin
          r.fin  = 1'b1;
          r.term = 1'b1;
        end else begin
          r.chan  = n[3:2];
          r.pend  = n;
          r.phase = PH_CTRL_LO;
        end
      end
      PH_CTRL_LO: begin
        m       = {s.pend[1:0], n};
        r.mask  = m;
        r.delta = '0;
        if (m == 6'd0) begin
          r = finish_rec(r, sl);
        end else begin
          r.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        // highest remaining mask bit
        for (int i = 0; i < 6; i++) begin
          if (s.mask[i]) begin
            b = 3'(i);
          end
        end
        r.delta = s.delta | ({{(SAMPLE_W-4){1'b0}}, n} << {b, 2'b00});
        r.mask  = s.mask & ~(6'd1 << b);
        if (r.mask == 6'd0) begin
          r = finish_rec(r, sl);
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // current state, or a fresh sector when the beat starts one
  always_comb begin
    if (in_first) begin
      cur     = '0;
      cur.phase = PH_HEADER;
      cur_cnt = '0;
      cur_pos = '0;
    end else begin
      cur.phase = phase_r;
      cur.pend  = pend_r;
      cur.mask  = mask_r;
      cur.chan  = chan_r;
      cur.delta = delta_r;
      cur.run   = run_r;
      cur.emit  = 1'b0;
      cur.term  = 1'b0;
      cur.fin   = fin_r;
      cur_cnt   = cnt_r;
      cur_pos   = pos_r;
    end
  end

  // header byte placement offsets
  assign hdr_base = POS_W'({sel, 2'b00}) + POS_W'(5);
  assign hdr_off  = cur_pos - hdr_base;

  // decode of one byte
  always_comb begin
    s0 = cur;
    s1 = cur;
    s2 = cur;
    if (!cur.fin) begin
      if (cur.phase == PH_HEADER) begin
        if (sel != 2'd0 && cur_pos >= hdr_base && hdr_off < POS_W'(3)) begin
          case (hdr_off[1:0])
            2'd0:    s0.run[23:16] = in_byte;
            2'd1:    s0.run[15:8]  = in_byte;
            default: s0.run[7:0]   = in_byte;
          endcase
        end
        if (cur_pos >= POS_W'(HEADER_END)) begin
          s0.phase = PH_CTRL_HI;
          if (sel != 2'd0) begin
            s0.emit = 1'b1;
          end
        end
        s2 = s0;
      end else begin
        s1 = nibble_step(cur, in_byte[7:4], sel);
        if (!s1.fin) begin
          s2 = nibble_step(s1, in_byte[3:0], sel);
        end else begin
          s2 = s1;
        end
      end
      // out of bytes
      if (!s2.fin && cur_pos == POS_LAST) begin
        s2.fin  = 1'b1;
        s2.term = 1'b0;
      end
    end
  end

  // sample count and byte position
  always_comb begin
    done    = !cur.fin && s2.fin;
    cnt_nxt = cur_cnt;
    if (s2.emit && cur_cnt != COUNT_W'(COUNT_MAX)) begin
      cnt_nxt = cur_cnt + COUNT_W'(1);
    end
    pos_nxt = cur.fin ? cur_pos : cur_pos + POS_W'(1);
  end

  // result beat
  always_comb begin
    res_valid        = fire && !cur.fin && (s2.emit || done);
    res.value        = s2.emit ? s2.run : '0;
    res.count        = cnt_nxt;
    res.sample_valid = s2.emit;
    res.done         = done;
    res.term         = done && s2.term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pend_r  <= '0;
      mask_r  <= '0;
      chan_r  <= '0;
      delta_r <= '0;
      run_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= s2.phase;
      pend_r  <= s2.pend;
      mask_r  <= s2.mask;
      chan_r  <= s2.chan;
      delta_r <= s2.delta;
      run_r   <= s2.run;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= s2.fin;
    end
  end

endmodule

>>> design/nxd_out_stage.sv
// ----------------------------------------------------------------------------
// nxd_out_stage
// Result register: holds one decoded beat until the sink takes it.
// ----------------------------------------------------------------------------
module nxd_out_stage
  import nxd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  res_t                  res,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample_value, sample_count, zero fill
  output logic                  out_tlast,  // sector_done
  output logic [1:0]            out_tuser   // sample_valid, terminated
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_DATA_W-SAMPLE_W-COUNT_W){1'b0}}, res_r.count, res_r.value};
  assign out_tlast  = res_r.done;
  assign out_tuser  = {res_r.term, res_r.sample_valid};

endmodule
